// ===== src/ilha_pkg.sv =====
// shared types and constants for the implicit-list heap allocator
// no dependencies

package ilha_pkg;

    localparam int NUM_UNITS_DEF  = 1024;
    localparam int HEAP_UNITS_W   = 11;
    localparam int HEAP_UNITS_RST = 1024;
    localparam int MODE_W         = 2;
    localparam int BYTES_W        = 15;
    localparam int UNIT_FIELD_W   = 10;
    localparam int UNIT_BYTES     = 16;
    localparam int UNIT_SHIFT     = 4;
    localparam int HDR_OVERHEAD   = 8;
    localparam int NEED_W         = 12;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORMAT = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [BYTES_W-1:0]      request_bytes;
        logic [UNIT_FIELD_W-1:0] free_unit;
    } req_t;

    typedef struct packed {
        logic                    status;
        logic [UNIT_FIELD_W-1:0] block_unit;
    } rsp_t;

    typedef struct packed {
        logic ge;
        logic eq;
    } alu_flags_t;

endpackage

// ===== src/ilha_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies

module ilha_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ilha_alu.sv =====
// shared adder and magnitude comparator used by every walk step
// depends on ilha_pkg

module ilha_alu #(
    parameter int W = 12
) (
    input  logic [W-1:0]            add_a,
    input  logic [W-1:0]            add_b,
    input  logic [W-1:0]            cmp_a,
    input  logic [W-1:0]            cmp_b,
    output logic [W-1:0]            sum,
    output logic [W-1:0]            diff,
    output ilha_pkg::alu_flags_t    flags
);

    import ilha_pkg::*;

    assign sum      = add_a + add_b;
    assign diff     = cmp_a - cmp_b;
    assign flags.ge = (cmp_a >= cmp_b);
    assign flags.eq = (cmp_a == cmp_b);

endmodule

// ===== src/implicit_list_heap_allocator.sv =====
// first-fit implicit-list heap allocator: sequencer, header memory and shared alu
// depends on ilha_pkg, ilha_ram, ilha_alu
//
// usage:
//   s_valid/s_ready carry one request transaction (mode, request_bytes, free_unit).
//   m_valid/m_ready carry exactly one response transaction per request
//   (status, block_unit). cfg_wen/cfg_wdata write heap_units and reformat the heap.
// sequencing:
//   one request is in flight at a time; s_ready is low while it runs.
//   allocate visits block headers in order until a free one fits, with a split
//   step when the fit is not exact. free walks the headers in front of the freed
//   block, frees it and merges a free next block (not when it is the last one in the heap)
//   and a free previous one. reformat, zero request, bad mode or out-of-range free: no walk.
//   each visited header costs one read of the header memory, whose registered
//   read port sets the one-block-per-cycle pace of the walk.
// reset and configuration:
//   after reset, and after every cfg write, the sequencer writes the first header
//   with a free block of the whole heap; s_ready stays low until that write is done.
// stalls:
//   the response sits in an output register; a request can be accepted while it
//   waits, but the next response waits in the sequencer until m_ready frees it.

module implicit_list_heap_allocator #(
    parameter int NUM_UNITS = ilha_pkg::NUM_UNITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [ilha_pkg::HEAP_UNITS_W-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ilha_pkg::req_t                      s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ilha_pkg::rsp_t                      m_data
);

    import ilha_pkg::*;

    localparam int UW = $clog2(NUM_UNITS);
    localparam int TW = UW + 1;
    localparam int HW = TW + 1;
    localparam int DW = (TW + 1 > NEED_W) ? TW + 1 : NEED_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_CHK,
        ST_A_SPLIT,
        ST_F_WALK,
        ST_F_CHK,
        ST_F_NEXT,
        ST_F_PREV,
        ST_RESP
    } state_t;

    state_t                    state_reg, state_next;
    logic [HEAP_UNITS_W-1:0]   heap_units_reg, heap_units_next;
    logic                      fmt_pend_reg, fmt_pend_next;
    logic [UW-1:0]             pos_reg, pos_next;
    logic [UW-1:0]             prev_reg, prev_next;
    logic [TW-1:0]             prev_sz_reg, prev_sz_next;
    logic                      prev_used_reg, prev_used_next;
    logic                      has_prev_reg, has_prev_next;
    logic [NEED_W-1:0]         need_reg, need_next;
    logic [TW-1:0]             rest_reg, rest_next;
    logic [TW-1:0]             cur_sz_reg, cur_sz_next;
    logic [UW-1:0]             tgt_reg, tgt_next;
    logic                      st_reg, st_next;
    logic [UNIT_FIELD_W-1:0]   unit_reg, unit_next;
    logic                      m_valid_reg, m_valid_next;
    rsp_t                      m_data_reg, m_data_next;

    logic [TW-1:0]             total;
    logic [BYTES_W:0]          byte_sum;
    logic [NEED_W-1:0]         need_val;
    logic                      unit_oob;

    logic                      mem_we;
    logic [UW-1:0]             mem_waddr;
    logic [HW-1:0]             mem_wdata;
    logic [UW-1:0]             mem_raddr;
    logic [HW-1:0]             mem_rdata;
    logic [TW-1:0]             hsz;
    logic                      hused;

    logic [DW-1:0]             alu_a, alu_b, alu_c, alu_d;
    logic [DW-1:0]             alu_sum, alu_diff;
    alu_flags_t                alu_flags;

    ilha_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_UNITS)
    ) u_hdr_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    ilha_alu #(
        .W (DW)
    ) u_alu (
        .add_a (alu_a),
        .add_b (alu_b),
        .cmp_a (alu_c),
        .cmp_b (alu_d),
        .sum   (alu_sum),
        .diff  (alu_diff),
        .flags (alu_flags)
    );

    // clamp heap length to 1..NUM_UNITS
    always_comb begin
        if (heap_units_reg == '0) begin
            total = TW'(1);
        end else if (32'(heap_units_reg) > 32'(NUM_UNITS)) begin
            total = TW'(NUM_UNITS);
        end else begin
            total = TW'(heap_units_reg);
        end
    end

    assign byte_sum = (BYTES_W + 1)'(s_data.request_bytes)
                    + (BYTES_W + 1)'(HDR_OVERHEAD + UNIT_BYTES - 1);
    assign need_val = NEED_W'(byte_sum >> UNIT_SHIFT);
    assign unit_oob = 32'(s_data.free_unit) >= 32'(total);

    assign hsz   = mem_rdata[HW-1:1];
    assign hused = mem_rdata[0];

    assign s_ready = (state_reg == ST_IDLE) && !fmt_pend_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        heap_units_next = cfg_wen ? cfg_wdata : heap_units_reg;
        fmt_pend_next   = fmt_pend_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        prev_sz_next    = prev_sz_reg;
        prev_used_next  = prev_used_reg;
        has_prev_next   = has_prev_reg;
        need_next       = need_reg;
        rest_next       = rest_reg;
        cur_sz_next     = cur_sz_reg;
        tgt_next        = tgt_reg;
        st_next         = st_reg;
        unit_next       = unit_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = '0;
        mem_raddr = pos_reg;

        alu_a = DW'(pos_reg);
        alu_b = DW'(hsz);
        alu_c = DW'(hsz);
        alu_d = DW'(need_reg);

        case (state_reg)
            ST_IDLE: begin
                if (fmt_pend_reg) begin
                    mem_we        = 1'b1;
                    mem_waddr     = '0;
                    mem_wdata     = {total, 1'b0};
                    fmt_pend_next = 1'b0;
                end else if (s_valid) begin
                    st_next       = STATUS_FAIL;
                    unit_next     = '0;
                    pos_next      = '0;
                    has_prev_next = 1'b0;
                    mem_raddr     = '0;
                    state_next    = ST_RESP;
                    case (s_data.mode)
                        MODE_ALLOC: begin
                            if (s_data.request_bytes != '0) begin
                                need_next  = need_val;
                                state_next = ST_A_CHK;
                            end
                        end
                        MODE_FREE: begin
                            if (!unit_oob) begin
                                tgt_next   = UW'(s_data.free_unit);
                                state_next = (s_data.free_unit == '0) ? ST_F_CHK : ST_F_WALK;
                            end
                        end
                        MODE_FORMAT: begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = {total, 1'b0};
                            st_next   = STATUS_OK;
                        end
                        default: begin
                            st_next = STATUS_FAIL;
                        end
                    endcase
                end
            end
            ST_A_CHK: begin
                if (hsz == '0) begin
                    state_next = ST_RESP;
                end else if (!hused && alu_flags.ge) begin
                    mem_we    = 1'b1;
                    unit_next = UNIT_FIELD_W'(pos_reg);
                    st_next   = STATUS_OK;
                    if (alu_flags.eq) begin
                        mem_wdata  = {hsz, 1'b1};
                        state_next = ST_RESP;
                    end else begin
                        mem_wdata  = {TW'(need_reg), 1'b1};
                        rest_next  = TW'(alu_diff);
                        state_next = ST_A_SPLIT;
                    end
                end else if (alu_sum >= DW'(total)) begin
                    state_next = ST_RESP;
                end else begin
                    pos_next  = UW'(alu_sum);
                    mem_raddr = UW'(alu_sum);
                end
            end
            ST_A_SPLIT: begin
                alu_b      = DW'(need_reg);
                mem_we     = 1'b1;
                mem_waddr  = UW'(alu_sum);
                mem_wdata  = {rest_reg, 1'b0};
                state_next = ST_RESP;
            end
            ST_F_WALK: begin
                alu_c = alu_sum;
                alu_d = DW'(tgt_reg);
                if (hsz == '0) begin
                    state_next = ST_RESP;
                end else begin
                    prev_next      = pos_reg;
                    prev_sz_next   = hsz;
                    prev_used_next = hused;
                    has_prev_next  = 1'b1;
                    pos_next       = UW'(alu_sum);
                    mem_raddr      = UW'(alu_sum);
                    if (alu_flags.eq) begin
                        state_next = ST_F_CHK;
                    end else if (alu_flags.ge) begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_F_CHK: begin
                alu_c = alu_sum;
                alu_d = DW'(total);
                if (!hused) begin
                    state_next = ST_RESP;
                end else begin
                    mem_we      = 1'b1;
                    mem_wdata   = {hsz, 1'b0};
                    cur_sz_next = hsz;
                    mem_raddr   = UW'(alu_sum);
                    state_next  = alu_flags.ge ? ST_F_PREV : ST_F_NEXT;
                end
            end
            ST_F_NEXT: begin
                alu_a = DW'(cur_sz_reg);
                if (!hused && hsz != '0) begin
                    mem_we      = 1'b1;
                    mem_wdata   = {TW'(alu_sum), 1'b0};
                    cur_sz_next = TW'(alu_sum);
                end
                state_next = ST_F_PREV;
            end
            ST_F_PREV: begin
                alu_a = DW'(prev_sz_reg);
                alu_b = DW'(cur_sz_reg);
                if (has_prev_reg && !prev_used_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = prev_reg;
                    mem_wdata = {TW'(alu_sum), 1'b0};
                end
                st_next    = STATUS_OK;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: st_reg, block_unit: unit_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wen) begin
            fmt_pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        prev_reg      <= prev_next;
        prev_sz_reg   <= prev_sz_next;
        prev_used_reg <= prev_used_next;
        has_prev_reg  <= has_prev_next;
        need_reg      <= need_next;
        rest_reg      <= rest_next;
        cur_sz_reg    <= cur_sz_next;
        tgt_reg       <= tgt_next;
        st_reg        <= st_next;
        unit_reg      <= unit_next;
        m_data_reg    <= m_data_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            heap_units_reg <= HEAP_UNITS_W'(HEAP_UNITS_RST);
            fmt_pend_reg   <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            heap_units_reg <= heap_units_next;
            fmt_pend_reg   <= fmt_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    a_walk_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_A_CHK || state_reg == ST_F_WALK || state_reg == ST_F_CHK)
        |-> ({1'b0, pos_reg} < total))
        else $error("walk position beyond heap length");

    a_no_zero_header: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_wdata[HW-1:1] != '0))
        else $error("zero-size header written");

    a_split_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_A_SPLIT) |-> (rest_reg != '0))
        else $error("split with empty remainder");

    a_cfg_blocks_req: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wen |=> !s_ready)
        else $error("request accepted before reformat after cfg write");

endmodule
